/* src/med_pkg.sv */
// ----------------------------------------------------------------------------
// Majority element detect package
// Shared types for the loader, the counting scan and the top level.
// ----------------------------------------------------------------------------
package med_pkg;

  // Top-level sequencer: loading elements, or counting over the stored set.
  typedef enum logic [0:0] {
    ST_LOAD,
    ST_SCAN
  } med_state_t;

  // Loader to scan: the set is closed by the item accepted this cycle.
  typedef struct packed {
    logic close;
    logic ovf;
  } med_close_t;

  // Scan to top level: verdict of the counting pass.
  typedef struct packed {
    logic done;
    logic found;
    logic ovf;
  } med_status_t;

endpackage

/* src/med_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are not reset.
// ----------------------------------------------------------------------------
module med_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic                                          rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/med_vote.sv */
// ----------------------------------------------------------------------------
// Majority element detect loader
// Writes each element into the store while it has room and keeps the running vote.
// ----------------------------------------------------------------------------
module med_vote #(
  parameter int DEPTH     = 1024,
  parameter int DATA_BITS = 32
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          accept,
  input  logic [DATA_BITS-1:0]                          elem,
  input  logic                                          last,
  output logic                                          wr_en,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  output logic [DATA_BITS-1:0]                          wr_data,
  output med_pkg::med_close_t                           close,
  output logic [DATA_BITS-1:0]                          sum_cand,
  output logic [$clog2(DEPTH+1)-1:0]                    sum_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        vcnt_r, vcnt_nxt;
  logic [DATA_BITS-1:0] cand_r, cand_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 full;

  assign full = (count_r == CW'(DEPTH));

  always_comb begin
    count_nxt = count_r;
    vcnt_nxt  = vcnt_r;
    cand_nxt  = cand_r;
    ovf_nxt   = ovf_r;
    wr_en     = 1'b0;
    if (accept) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        wr_en     = 1'b1;
        count_nxt = count_r + 1'b1;
        if (vcnt_r == '0) begin
          cand_nxt = elem;
          vcnt_nxt = CW'(1);
        end else if (cand_r == elem) begin
          vcnt_nxt = vcnt_r + 1'b1;
        end else begin
          vcnt_nxt = vcnt_r - 1'b1;
        end
      end
    end
  end

  assign wr_addr     = count_r[AW-1:0];
  assign wr_data     = elem;
  assign close.close = accept && last;
  assign close.ovf   = ovf_nxt;
  assign sum_cand    = cand_nxt;
  assign sum_count   = count_nxt;

  // The item that closes a set leaves the loader clear for the next set.
  always_ff @(posedge clk) begin
    if (!rst_n || close.close) begin
      count_r <= '0;
      vcnt_r  <= '0;
      cand_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      vcnt_r  <= vcnt_nxt;
      cand_r  <= cand_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count exceeds store depth");

  a_vote_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r <= count_r)
    else $error("vote weight exceeds element count");

endmodule

/* src/med_scan.sv */
// ----------------------------------------------------------------------------
// Majority element detect counting scan
// Reads the stored set once and counts entries equal to the vote candidate.
// ----------------------------------------------------------------------------
module med_scan #(
  parameter int DEPTH     = 1024,
  parameter int DATA_BITS = 32
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  med_pkg::med_close_t                           close,
  input  logic [DATA_BITS-1:0]                          sum_cand,
  input  logic [$clog2(DEPTH+1)-1:0]                    sum_count,
  input  logic                                          take,
  output logic                                          rd_en,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  input  logic [DATA_BITS-1:0]                          rd_data,
  output med_pkg::med_status_t                          status,
  output logic [DATA_BITS-1:0]                          cand
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                 busy_r;
  logic                 pend_r;
  logic                 ovf_r;
  logic [CW-1:0]        addr_r;
  logic [CW-1:0]        total_r;
  logic [CW-1:0]        hits_r;
  logic [DATA_BITS-1:0] cand_r;

  assign rd_en   = busy_r && (addr_r != total_r);
  assign rd_addr = addr_r[AW-1:0];

  assign status.done  = busy_r && (addr_r == total_r) && !pend_r;
  assign status.found = (total_r != '0) && ({hits_r, 1'b0} > {1'b0, total_r});
  assign status.ovf   = ovf_r;
  assign cand         = cand_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
    end else if (close.close) begin
      busy_r <= 1'b1;
      pend_r <= 1'b0;
    end else begin
      if (status.done && take) begin
        busy_r <= 1'b0;
      end
      pend_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (close.close) begin
      cand_r  <= sum_cand;
      total_r <= sum_count;
      ovf_r   <= close.ovf;
      addr_r  <= '0;
      hits_r  <= '0;
    end else begin
      if (rd_en) begin
        addr_r <= addr_r + 1'b1;
      end
      if (pend_r && (rd_data == cand_r)) begin
        hits_r <= hits_r + 1'b1;
      end
    end
  end

  a_hits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (hits_r <= addr_r))
    else $error("hit count runs ahead of scan address");

endmodule

/* src/majority_element_detect.sv */
// ----------------------------------------------------------------------------
// Majority element detect
// Loads a set of signed elements and reports a strict-majority value.
// ----------------------------------------------------------------------------
// Throughput: one element is taken per cycle while a set loads; in_stall is
// high during the counting pass, which reads one stored element per cycle.
// After the closing item the scan reads every stored element, counts the
// matches and then hands the verdict to the output register.
// The store's single read port sets the length of the counting pass.
// Reset (rst_n low, synchronous) clears the sequencer, loader counters and
// busy and valid flags; the store keeps its contents and is not cleared.
module majority_element_detect #(
  parameter int DEPTH     = 1024,
  parameter int DATA_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_element_value,
  input  logic               in_last_element,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_has_majority,
  output logic signed [31:0] out_majority_value,
  output logic               out_set_overflow
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  med_pkg::med_state_t  state_r, state_nxt;
  med_pkg::med_close_t  close;
  med_pkg::med_status_t status;

  logic                 in_accept;
  logic                 take;
  logic [DATA_BITS-1:0] elem;
  logic [DATA_BITS-1:0] sum_cand;
  logic [CW-1:0]        sum_count;
  logic [DATA_BITS-1:0] cand;
  logic [31:0]          cand32;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [DATA_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [DATA_BITS-1:0] rd_data;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r;
  logic [31:0]          out_value_r;
  logic                 out_ovf_r;

  // Only the low DATA_BITS bits of an element are kept. A wider store holds
  // the element sign-extended.
  generate
    if (DATA_BITS <= 32) begin : g_in_narrow
      assign elem = in_element_value[DATA_BITS-1:0];
    end else begin : g_in_wide
      assign elem = {{(DATA_BITS-32){in_element_value[31]}}, in_element_value};
    end
  endgenerate

  // The reported value is the kept pattern, masked or zero-filled to 32 bits.
  generate
    if (DATA_BITS >= 32) begin : g_out_wide
      assign cand32 = cand[31:0];
    end else begin : g_out_narrow
      assign cand32 = {{(32-DATA_BITS){1'b0}}, cand};
    end
  endgenerate

  // Elements are accepted only while loading. The store is never read while
  // it is written, so the loader and the scan need no forwarding.
  assign in_stall  = (state_r != med_pkg::ST_LOAD);
  assign in_accept = in_valid && !in_stall;

  // A finished verdict moves into the output register once that register is
  // empty or being drained this cycle.
  assign take = status.done && (!out_valid_r || !out_stall);

  med_vote #(
    .DEPTH     (DEPTH),
    .DATA_BITS (DATA_BITS)
  ) u_vote (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .elem      (elem),
    .last      (in_last_element),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .close     (close),
    .sum_cand  (sum_cand),
    .sum_count (sum_count)
  );

  med_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  med_scan #(
    .DEPTH     (DEPTH),
    .DATA_BITS (DATA_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .close     (close),
    .sum_cand  (sum_cand),
    .sum_count (sum_count),
    .take      (take),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .status    (status),
    .cand      (cand)
  );

  // Sequencer: the closing item starts the scan, and handing the verdict to
  // the output register returns the block to loading.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= med_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      med_pkg::ST_LOAD: begin
        if (close.close) begin
          state_nxt = med_pkg::ST_SCAN;
        end
      end
      med_pkg::ST_SCAN: begin
        if (take) begin
          state_nxt = med_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = med_pkg::ST_LOAD;
      end
    endcase
  end

  // Output register. It holds a result under stall while the loader already
  // takes elements of the next set.
  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_found_r <= status.found;
      out_value_r <= status.found ? cand32 : 32'd0;
      out_ovf_r   <= status.ovf;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_has_majority   = out_found_r;
  assign out_majority_value = out_value_r;
  assign out_set_overflow   = out_ovf_r;

  a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_element) |=> in_stall)
    else $error("input not stalled after the closing item");

  a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == med_pkg::ST_SCAN))
    else $error("result raised outside a counting pass");

endmodule
